### hw/rtl/qpht_pkg.sv
// Shared constants, codes and types for the quadratic-probe hash table.
package qpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 31;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int PROBE_W     = SLOT_W + 1;
    localparam int CNT_W       = 32;
    localparam int IN_DATA_W   = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 1 + SLOT_W + PROBE_W + 2 * CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);

    // operation codes carried in tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // result of the modulo unit
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } qpht_mod_res_t;

endpackage

### hw/rtl/qpht_ram.sv
// Generic single-port synchronous RAM with registered read data.
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/qpht_mod.sv
// Restoring remainder unit: key mod table size, one dividend bit per cycle.
module qpht_mod
    import qpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output qpht_mod_res_t     res
);

    localparam int STEP_W = $clog2(KEY_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [SIZE_W-1:0] rem_reg;

    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic [SIZE_W-1:0] rem_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[SIZE_W-1:0];
        end
        else
        begin
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // remainder is below the size, so it fits a slot index
    assign res.done = done_reg;
    assign res.rem  = rem_reg[SLOT_W-1:0];

endmodule

### hw/rtl/quadratic_probe_hash_table.sv
// Top level: quadratic-probe open-addressing hash table with probe statistics.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------------
//  s_axis   | in  | tvalid/tready         | tdata: key ; tuser: cmd
//  m_axis   | out | tvalid/tready         | tdata: ok, slot, probes, total, searches
//  cfg      | in  | cfg_we (no wait)      | cfg_wdata: table_size
//
//  An item first has key mod size computed in the remainder unit, then each
//  probed slot goes through ST_READ (RAM read), then ST_CHECK (check and
//  write), and the item ends in ST_OUT. At most size + 1 slots are probed.
//  After reset a sweep zeroes all 1024 key RAM entries; no item is taken meanwhile.
//  A finished result waits in the output register; the next item is accepted
//  while it waits, and only a second finished result stalls on m_axis_tready.
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[30:0], zero pad
    input  logic                  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // ok, slot, probes, total_probes,
                                                  // search_count, zero pad
    input  logic                  cfg_we,
    input  logic [SIZE_W-1:0]     cfg_wdata       // table_size
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [SIZE_W-1:0]  size_cfg_reg;
    logic [SLOT_W-1:0]  clr_reg;
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SLOT_W-1:0]  probe_reg;
    logic [SLOT_W-1:0]  odd_reg;
    logic [SIZE_W-1:0]  step_reg;
    logic               res_ok_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [PROBE_W-1:0] res_probes_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   searches_reg;
    logic               m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [SIZE_W-1:0]  size_live;
    logic               accept;
    qpht_mod_res_t      mod_res;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_addr;
    logic [KEY_W-1:0]   ram_wdata;
    logic [KEY_W-1:0]   ram_rdata;
    logic               hit;
    logic               empty;
    logic               last;
    logic [SIZE_W-1:0]  psum;
    logic [SLOT_W-1:0]  probe_next;
    logic [SIZE_W-1:0]  osum;
    logic [SLOT_W-1:0]  odd_next;
    logic [PROBE_W-1:0] probes_now;
    logic [CNT_W:0]     total_sum;
    logic [CNT_W:0]     search_sum;
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   searches_next;
    logic               out_free;

    // size in use, clamped to the table
    always_comb
    begin
        size_live = size_cfg_reg;
        if (size_cfg_reg < SIZE_MIN)
        begin
            size_live = SIZE_MIN;
        end
        else if (size_cfg_reg > SIZE_MAX)
        begin
            size_live = SIZE_MAX;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    qpht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (s_axis_tdata[KEY_W-1:0]),
        .divisor  (size_live),
        .res      (mod_res)
    );

    // key RAM: sweep clear after reset, else probe address
    always_comb
    begin
        ram_addr  = (state_reg == ST_CLEAR) ? clr_reg : probe_reg;
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : key_reg;
        ram_we    = (state_reg == ST_CLEAR) ||
                    ((state_reg == ST_CHECK) && (cmd_reg == CMD_INSERT) &&
                     (key_reg != '0) && (ram_rdata == '0));
    end

    qpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // probe check and next quadratic offset: p += 2j-1, both mod size
    always_comb
    begin
        hit        = (ram_rdata == key_reg);
        empty      = (ram_rdata == '0);
        last       = (step_reg == size_live);
        probes_now = step_reg + PROBE_W'(1);

        psum = {1'b0, probe_reg} + {1'b0, odd_reg};
        if (psum >= size_live)
        begin
            psum = psum - size_live;
        end
        probe_next = psum[SLOT_W-1:0];

        osum = {1'b0, odd_reg} + SIZE_W'(2);
        if (osum >= size_live)
        begin
            osum = osum - size_live;
        end
        odd_next = osum[SLOT_W-1:0];
    end

    // saturating statistics
    always_comb
    begin
        total_sum  = {1'b0, total_reg} + {{(CNT_W + 1 - PROBE_W){1'b0}}, res_probes_reg};
        search_sum = {1'b0, searches_reg} + (CNT_W + 1)'(1);
        total_next    = total_reg;
        searches_next = searches_reg;
        if (cmd_reg == CMD_SEARCH)
        begin
            total_next    = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
            searches_next = search_sum[CNT_W] ? '1 : search_sum[CNT_W-1:0];
        end
        out_free = !m_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_cfg_reg <= cfg_wdata;
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            total_reg    <= '0;
            searches_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            // result register: loaded when leaving ST_OUT, freed on handshake
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                    if (clr_reg == SLOT_W'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (mod_res.done)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if ((key_reg == '0) || empty || last)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        if (hit || empty || last)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        total_reg    <= total_next;
                        searches_reg <= searches_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_axis_tuser;
            key_reg <= s_axis_tdata[KEY_W-1:0];
        end
        if ((state_reg == ST_DIV) && mod_res.done)
        begin
            probe_reg <= mod_res.rem;
            odd_reg   <= SLOT_W'(1);
            step_reg  <= '0;
        end
        if (state_reg == ST_CHECK)
        begin
            probe_reg <= probe_next;
            odd_reg   <= odd_next;
            step_reg  <= step_reg + SIZE_W'(1);
            if (cmd_reg == CMD_INSERT)
            begin
                res_probes_reg <= '0;
                res_ok_reg     <= (key_reg != '0) && empty;
                res_slot_reg   <= ((key_reg != '0) && empty) ? probe_reg : '0;
            end
            else
            begin
                res_probes_reg <= probes_now;
                res_ok_reg     <= (key_reg != '0) && hit;
                res_slot_reg   <= ((key_reg != '0) && hit) ? probe_reg : '0;
            end
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_data_reg <= {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, searches_next, total_next,
                           res_probes_reg, res_slot_reg, res_ok_reg};
        end
    end

endmodule
